FILE: src/spcd_pkg.sv
// Shared package for the strict-priority call dispatcher.
// Holds field widths, operation and report codes, and controller types.
// No dependencies; every other file refers to it by scoped names.
package spcd_pkg;

    localparam int DEF_CLASS_COUNT = 4;
    localparam int DEF_QUEUE_DEPTH = 16;

    localparam int OP_W    = 2;
    localparam int ID_W    = 8;
    localparam int CLASS_W = 2;
    localparam int SVC_W   = 16;
    localparam int KIND_W  = 2;
    localparam int TICK_W  = 32;
    localparam int ENTRY_W = ID_W + SVC_W;

    localparam logic [OP_W-1:0] OP_BEGIN  = 2'd0;
    localparam logic [OP_W-1:0] OP_ARRIVE = 2'd1;
    localparam logic [OP_W-1:0] OP_END    = 2'd2;

    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ARRIVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DROP   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ANSWER = 2'd3;

    typedef enum logic {
        ST_IDLE,
        ST_ANSWER
    } t_state;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_BEGIN,
        CMD_ARRIVE,
        CMD_TICK,
        CMD_DISPATCH,
        CMD_ANSWER
    } t_cmd;

    typedef struct packed {
        logic server_idle;
        logic any_waiting;
    } t_status;

endpackage

FILE: src/spcd_ctrl.sv
// Controller state machine of the call dispatcher.
// Decodes accepted operations into datapath commands; uses spcd_pkg.
// Adds an answer state when an end tick dispatches a waiting call.
module spcd_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    input  logic [spcd_pkg::OP_W-1:0] i_op,
    input  spcd_pkg::t_status         i_status,
    output logic                      o_busy,
    output spcd_pkg::t_cmd            o_cmd
);

    spcd_pkg::t_state r_state;
    spcd_pkg::t_state n_state;
    logic             can_dispatch;

    assign can_dispatch = i_status.server_idle && i_status.any_waiting;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spcd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            spcd_pkg::ST_IDLE: begin
                if (start && (i_op == spcd_pkg::OP_END) && can_dispatch) begin
                    n_state = spcd_pkg::ST_ANSWER;
                end
            end
            spcd_pkg::ST_ANSWER: begin
                n_state = spcd_pkg::ST_IDLE;
            end
            default: begin
                n_state = spcd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd  = spcd_pkg::CMD_NONE;
        o_busy = 1'b0;
        unique case (r_state)
            spcd_pkg::ST_IDLE: begin
                if (start) begin
                    unique case (i_op)
                        spcd_pkg::OP_BEGIN:  o_cmd = spcd_pkg::CMD_BEGIN;
                        spcd_pkg::OP_ARRIVE: o_cmd = spcd_pkg::CMD_ARRIVE;
                        spcd_pkg::OP_END: begin
                            o_cmd = can_dispatch ? spcd_pkg::CMD_DISPATCH
                                                 : spcd_pkg::CMD_TICK;
                        end
                        default: o_cmd = spcd_pkg::CMD_NONE;
                    endcase
                end
            end
            spcd_pkg::ST_ANSWER: begin
                o_busy = 1'b1;
                o_cmd  = spcd_pkg::CMD_ANSWER;
            end
            default: begin
                o_cmd = spcd_pkg::CMD_NONE;
            end
        endcase
    end

endmodule

FILE: src/spcd_dp.sv
// Datapath of the call dispatcher: per-class FIFO pointers, the call store,
// the server busy count, the tick counter and the report register.
// Driven by commands from spcd_ctrl; uses spcd_pkg.
module spcd_dp #(
    parameter int CLASS_COUNT = spcd_pkg::DEF_CLASS_COUNT,
    parameter int QUEUE_DEPTH = spcd_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  spcd_pkg::t_cmd                i_cmd,
    input  logic [spcd_pkg::ID_W-1:0]     i_caller_id,
    input  logic [spcd_pkg::CLASS_W-1:0]  i_caller_class,
    input  logic [spcd_pkg::SVC_W-1:0]    i_service_time,
    output spcd_pkg::t_status             o_status,
    output logic                          o_valid,
    output logic [spcd_pkg::KIND_W-1:0]   o_kind,
    output logic [spcd_pkg::TICK_W-1:0]   o_tick_number,
    output logic [spcd_pkg::ID_W-1:0]     o_who,
    output logic [spcd_pkg::CLASS_W-1:0]  o_which_class
);

    localparam int CW    = $clog2(CLASS_COUNT);
    localparam int PW    = $clog2(QUEUE_DEPTH);
    localparam int FW    = $clog2(QUEUE_DEPTH + 1);
    localparam int DEPTH = CLASS_COUNT * QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    logic [FW-1:0] r_fill [CLASS_COUNT];
    logic [PW-1:0] r_head [CLASS_COUNT];
    logic [PW-1:0] r_tail [CLASS_COUNT];

    logic [spcd_pkg::ENTRY_W-1:0] r_mem [DEPTH];
    logic [spcd_pkg::ENTRY_W-1:0] r_rd_data;
    logic [CW-1:0]                r_disp_cls;

    logic [spcd_pkg::SVC_W-1:0]   r_busy_left;
    logic [spcd_pkg::TICK_W-1:0]  r_tick_count;

    logic                         r_valid;
    logic [spcd_pkg::KIND_W-1:0]  r_kind;
    logic [spcd_pkg::TICK_W-1:0]  r_tick_number;
    logic [spcd_pkg::ID_W-1:0]    r_who;
    logic [spcd_pkg::CLASS_W-1:0] r_which_class;

    logic [CW-1:0] pick_cls;
    logic          any_waiting;
    logic [CW-1:0] arr_cls;
    logic          arr_drop;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [spcd_pkg::SVC_W-1:0] ans_svc;

    function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] ptr);
        return (ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : ptr + PW'(1);
    endfunction

    function automatic logic [spcd_pkg::SVC_W-1:0] dec_sat(
        input logic [spcd_pkg::SVC_W-1:0] val
    );
        return (val == '0) ? '0 : val - spcd_pkg::SVC_W'(1);
    endfunction

    // The highest-numbered non-empty class wins.
    always_comb begin
        pick_cls    = '0;
        any_waiting = 1'b0;
        for (int c = 0; c < CLASS_COUNT; c++) begin
            if (r_fill[c] != '0) begin
                pick_cls    = CW'(c);
                any_waiting = 1'b1;
            end
        end
    end

    assign arr_cls  = CW'(i_caller_class);
    assign arr_drop = (32'(i_caller_class) >= 32'(CLASS_COUNT))
                   || (r_fill[arr_cls] == FW'(QUEUE_DEPTH));
    assign wr_addr  = AW'(arr_cls) * AW'(QUEUE_DEPTH) + AW'(r_tail[arr_cls]);
    assign rd_addr  = AW'(pick_cls) * AW'(QUEUE_DEPTH) + AW'(r_head[pick_cls]);
    assign ans_svc  = r_rd_data[spcd_pkg::SVC_W-1:0];

    assign o_status.server_idle = (r_busy_left == '0);
    assign o_status.any_waiting = any_waiting;

    always_ff @(posedge i_clk) begin
        if ((i_cmd == spcd_pkg::CMD_ARRIVE) && !arr_drop) begin
            r_mem[wr_addr] <= {i_caller_id, i_service_time};
        end
        if (i_cmd == spcd_pkg::CMD_DISPATCH) begin
            r_rd_data  <= r_mem[rd_addr];
            r_disp_cls <= pick_cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CLASS_COUNT; c++) begin
                r_fill[c] <= '0;
                r_head[c] <= '0;
                r_tail[c] <= '0;
            end
            r_busy_left  <= '0;
            r_tick_count <= '0;
            r_valid      <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (i_cmd)
                spcd_pkg::CMD_BEGIN: begin
                    r_valid       <= 1'b1;
                    r_kind        <= spcd_pkg::KIND_TICK;
                    r_tick_number <= r_tick_count;
                    r_who         <= '0;
                    r_which_class <= '0;
                end
                spcd_pkg::CMD_ARRIVE: begin
                    r_valid       <= 1'b1;
                    r_kind        <= arr_drop ? spcd_pkg::KIND_DROP : spcd_pkg::KIND_ARRIVE;
                    r_tick_number <= r_tick_count;
                    r_who         <= i_caller_id;
                    r_which_class <= i_caller_class;
                    if (!arr_drop) begin
                        r_tail[arr_cls] <= next_slot(r_tail[arr_cls]);
                        r_fill[arr_cls] <= r_fill[arr_cls] + FW'(1);
                    end
                end
                spcd_pkg::CMD_TICK: begin
                    r_busy_left  <= dec_sat(r_busy_left);
                    r_tick_count <= r_tick_count + spcd_pkg::TICK_W'(1);
                end
                spcd_pkg::CMD_DISPATCH: begin
                    r_head[pick_cls] <= next_slot(r_head[pick_cls]);
                    r_fill[pick_cls] <= r_fill[pick_cls] - FW'(1);
                end
                spcd_pkg::CMD_ANSWER: begin
                    r_valid       <= 1'b1;
                    r_kind        <= spcd_pkg::KIND_ANSWER;
                    r_tick_number <= r_tick_count;
                    r_who         <= r_rd_data[spcd_pkg::ENTRY_W-1:spcd_pkg::SVC_W];
                    r_which_class <= spcd_pkg::CLASS_W'(r_disp_cls);
                    r_busy_left   <= dec_sat(ans_svc);
                    r_tick_count  <= r_tick_count + spcd_pkg::TICK_W'(1);
                end
                default: begin
                    r_valid <= 1'b0;
                end
            endcase
        end
    end

    assign o_valid       = r_valid;
    assign o_kind        = r_kind;
    assign o_tick_number = r_tick_number;
    assign o_who         = r_who;
    assign o_which_class = r_which_class;

    // A call is only taken from a queue while the server is idle.
    a_dispatch_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == spcd_pkg::CMD_DISPATCH) |-> (r_busy_left == '0) && any_waiting)
        else $error("dispatch while server busy or all queues empty");

    // Every answer cycle produces an answer report on the next cycle.
    a_answer_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == spcd_pkg::CMD_ANSWER)
        |=> o_valid && (o_kind == spcd_pkg::KIND_ANSWER))
        else $error("answer cycle without answer report");

    // An end tick that dispatches nothing produces no report.
    a_tick_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == spcd_pkg::CMD_TICK) |=> !o_valid)
        else $error("report after an end tick without dispatch");

    // The tick counter advances only on end ticks.
    a_tick_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == spcd_pkg::CMD_BEGIN || i_cmd == spcd_pkg::CMD_ARRIVE)
        |=> $stable(r_tick_count))
        else $error("tick counter moved outside an end tick");

endmodule

FILE: src/strict_priority_call_dispatcher_top.sv
// Top level of the strict-priority call dispatcher.
// Instantiates spcd_ctrl and spcd_dp; uses spcd_pkg.
//
// Channel   Direction  Handshake                      Fields
// command   in         start high, busy low           i_op, i_caller_id, i_caller_class,
//                                                      i_service_time
// report    out        o_valid, one cycle, no stall   o_kind, o_tick_number, o_who,
//                                                      o_which_class
//
// Begin tick, arrival and an end tick that dispatches nothing complete as they are accepted.
// An end tick that dispatches then enters an answer state that reads the call store's
// registered port, and busy is high during it.
// A report appears in the cycle after the edge that completes its command.
// Reset is synchronous and empties all queues and zeroes busy and tick counts;
// the call store contents are undefined after reset and need no clearing.
// The receiver cannot stall, so each report is transferred in its one cycle.
module strict_priority_call_dispatcher_top #(
    parameter int CLASS_COUNT = spcd_pkg::DEF_CLASS_COUNT,
    parameter int QUEUE_DEPTH = spcd_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [spcd_pkg::OP_W-1:0]     i_op,
    input  logic [spcd_pkg::ID_W-1:0]     i_caller_id,
    input  logic [spcd_pkg::CLASS_W-1:0]  i_caller_class,
    input  logic [spcd_pkg::SVC_W-1:0]    i_service_time,
    output logic                          o_valid,
    output logic [spcd_pkg::KIND_W-1:0]   o_kind,
    output logic [spcd_pkg::TICK_W-1:0]   o_tick_number,
    output logic [spcd_pkg::ID_W-1:0]     o_who,
    output logic [spcd_pkg::CLASS_W-1:0]  o_which_class
);

    spcd_pkg::t_cmd    cmd;
    spcd_pkg::t_status status;

    spcd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_op     (i_op),
        .i_status (status),
        .o_busy   (busy),
        .o_cmd    (cmd)
    );

    spcd_dp #(
        .CLASS_COUNT (CLASS_COUNT),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_caller_id    (i_caller_id),
        .i_caller_class (i_caller_class),
        .i_service_time (i_service_time),
        .o_status       (status),
        .o_valid        (o_valid),
        .o_kind         (o_kind),
        .o_tick_number  (o_tick_number),
        .o_who          (o_who),
        .o_which_class  (o_which_class)
    );

endmodule

FILE: verif/tb_strict_priority_call_dispatcher_top.sv
// Testbench for strict_priority_call_dispatcher_top: directed and random command traffic.
// A local dispatcher model predicts every report; a monitor checks each report transfer.
// Depends on spcd_pkg and the RTL under src/.
module tb_strict_priority_call_dispatcher_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_CLASSES = spcd_pkg::DEF_CLASS_COUNT;
    localparam int FIFO_DEPTH  = spcd_pkg::DEF_QUEUE_DEPTH;
    localparam int OP_W        = spcd_pkg::OP_W;
    localparam int ID_W        = spcd_pkg::ID_W;
    localparam int CLASS_W     = spcd_pkg::CLASS_W;
    localparam int SVC_W       = spcd_pkg::SVC_W;
    localparam int KIND_W      = spcd_pkg::KIND_W;
    localparam int TICK_W      = spcd_pkg::TICK_W;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [SVC_W-1:0] svc;
    } t_call;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [TICK_W-1:0]  tick;
        logic [ID_W-1:0]    who;
        logic [CLASS_W-1:0] cls;
    } t_report;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                start          = 1'b0;
    logic [OP_W-1:0]     i_op           = '0;
    logic [ID_W-1:0]     i_caller_id    = '0;
    logic [CLASS_W-1:0]  i_caller_class = '0;
    logic [SVC_W-1:0]    i_service_time = '0;
    logic                busy;
    logic                o_valid;
    logic [KIND_W-1:0]   o_kind;
    logic [TICK_W-1:0]   o_tick_number;
    logic [ID_W-1:0]     o_who;
    logic [CLASS_W-1:0]  o_which_class;

    t_call             waiting_calls[NUM_CLASSES][$];
    logic [SVC_W-1:0]  server_busy_left;
    logic [TICK_W-1:0] tick_counter;
    t_report           expected_reports[$];
    int                error_count;
    bit                gaps_on;

    strict_priority_call_dispatcher_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_caller_id    (i_caller_id),
        .i_caller_class (i_caller_class),
        .i_service_time (i_service_time),
        .o_valid        (o_valid),
        .o_kind         (o_kind),
        .o_tick_number  (o_tick_number),
        .o_who          (o_who),
        .o_which_class  (o_which_class)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_PRINTED) begin
            $display("[%0t] ERROR: %s", $realtime, msg);
        end
        error_count++;
    endtask

    function automatic void predict_dispatch(input logic [OP_W-1:0] op,
                                             input logic [ID_W-1:0] id,
                                             input logic [CLASS_W-1:0] cls,
                                             input logic [SVC_W-1:0] svc);
        t_report rep;
        t_call   head;
        bit      found;
        found = 1'b0;
        rep = '0;
        rep.tick = tick_counter;
        case (op)
            spcd_pkg::OP_BEGIN: begin
                rep.kind = spcd_pkg::KIND_TICK;
                expected_reports.push_back(rep);
            end
            spcd_pkg::OP_ARRIVE: begin
                rep.who = id;
                rep.cls = cls;
                if (int'(cls) >= NUM_CLASSES || waiting_calls[cls].size() >= FIFO_DEPTH) begin
                    rep.kind = spcd_pkg::KIND_DROP;
                end else begin
                    waiting_calls[cls].push_back('{id: id, svc: svc});
                    rep.kind = spcd_pkg::KIND_ARRIVE;
                end
                expected_reports.push_back(rep);
            end
            spcd_pkg::OP_END: begin
                if (server_busy_left == '0) begin
                    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
                        if (!found && waiting_calls[c].size() != 0) begin
                            found = 1'b1;
                            head = waiting_calls[c].pop_front();
                            server_busy_left = head.svc;
                            rep.kind = spcd_pkg::KIND_ANSWER;
                            rep.who = head.id;
                            rep.cls = CLASS_W'(c);
                            expected_reports.push_back(rep);
                        end
                    end
                end
                if (server_busy_left != '0) begin
                    server_busy_left--;
                end
                tick_counter++;
            end
            default: begin
            end
        endcase
    endfunction

    task automatic send_command(input logic [OP_W-1:0] op,
                                input logic [ID_W-1:0] id,
                                input logic [CLASS_W-1:0] cls,
                                input logic [SVC_W-1:0] svc);
        int gap;
        gap = gaps_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_op           <= op;
        i_caller_id    <= id;
        i_caller_class <= cls;
        i_service_time <= svc;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        predict_dispatch(op, id, cls, svc);
    endtask

    function automatic logic [SVC_W-1:0] pick_service(input bit heavy);
        if ($urandom_range(0, 99) < 85) return SVC_W'($urandom_range(0, heavy ? 4 : 2));
        return SVC_W'($urandom_range(5, 20));
    endfunction

    function automatic bit calls_pending();
        for (int c = 0; c < NUM_CLASSES; c++) begin
            if (waiting_calls[c].size() != 0) return 1'b1;
        end
        return server_busy_left != '0;
    endfunction

    always @(posedge i_clk) begin
        t_report exp_rep;
        if (i_rst_n && o_valid) begin
            if (expected_reports.size() == 0) begin
                report_mismatch($sformatf("unexpected report kind %0d who %0h", o_kind, o_who));
            end else begin
                exp_rep = expected_reports.pop_front();
                if (o_kind !== exp_rep.kind)
                    report_mismatch($sformatf("kind %0d, expected %0d", o_kind, exp_rep.kind));
                if (o_tick_number !== exp_rep.tick)
                    report_mismatch($sformatf("tick %0d, expected %0d",
                                              o_tick_number, exp_rep.tick));
                if (o_who !== exp_rep.who)
                    report_mismatch($sformatf("who %0h, expected %0h", o_who, exp_rep.who));
                if (o_which_class !== exp_rep.cls)
                    report_mismatch($sformatf("class %0d, expected %0d",
                                              o_which_class, exp_rep.cls));
            end
        end
    end

    task automatic test_tick_and_ignored_op();
        send_command(spcd_pkg::OP_BEGIN, '0, '0, '0);
        send_command(OP_UNUSED, 8'hFF, 2'd3, 16'hFFFF);
        send_command(spcd_pkg::OP_END, '0, '0, '0);
        send_command(spcd_pkg::OP_BEGIN, 8'hFF, 2'd3, 16'hFFFF);
    endtask

    task automatic test_priority_and_busy();
        send_command(spcd_pkg::OP_ARRIVE, 8'h00, 2'd0, 16'd2);
        send_command(spcd_pkg::OP_ARRIVE, 8'hFF, 2'd3, 16'd0);
        send_command(spcd_pkg::OP_END, '0, '0, '0);
        send_command(spcd_pkg::OP_END, '0, '0, '0);
        send_command(spcd_pkg::OP_END, '0, '0, '0);
        send_command(spcd_pkg::OP_END, '0, '0, '0);
    endtask

    task automatic test_queue_overflow();
        for (int n = 0; n <= FIFO_DEPTH; n++) begin
            send_command(spcd_pkg::OP_ARRIVE, ID_W'($urandom_range(0, 255)), 2'd2, '0);
        end
    endtask

    task automatic test_random_traffic(input int item_count);
        int  roll;
        bit  heavy;
        logic [CLASS_W-1:0] burst_cls;
        heavy = 1'b0;
        for (int n = 0; n < item_count; n++) begin
            if (n % 100 == 0) begin
                heavy = ~heavy;
                gaps_on = ($urandom_range(0, 3) != 0);
            end
            roll = $urandom_range(0, 99);
            if (roll < 2) begin
                burst_cls = CLASS_W'($urandom_range(0, NUM_CLASSES - 1));
                for (int b = 0; b < FIFO_DEPTH + 2; b++) begin
                    send_command(spcd_pkg::OP_ARRIVE, ID_W'($urandom_range(0, 255)),
                                 burst_cls, pick_service(1'b0));
                end
                n += FIFO_DEPTH + 1;
            end else if (roll < 7) begin
                send_command(OP_UNUSED, ID_W'($urandom_range(0, 255)),
                             CLASS_W'($urandom_range(0, 3)), SVC_W'($urandom));
            end else if (roll < 20) begin
                send_command(spcd_pkg::OP_BEGIN, ID_W'($urandom_range(0, 255)),
                             CLASS_W'($urandom_range(0, 3)), SVC_W'($urandom));
            end else if (roll < (heavy ? 65 : 40)) begin
                send_command(spcd_pkg::OP_ARRIVE, ID_W'($urandom_range(0, 255)),
                             CLASS_W'($urandom_range(0, NUM_CLASSES - 1)), pick_service(heavy));
            end else begin
                send_command(spcd_pkg::OP_END, ID_W'($urandom_range(0, 255)),
                             CLASS_W'($urandom_range(0, 3)), SVC_W'($urandom));
            end
        end
    endtask

    task automatic test_long_service();
        while (calls_pending()) begin
            send_command(spcd_pkg::OP_END, '0, '0, '0);
        end
        send_command(spcd_pkg::OP_ARRIVE, 8'hA5, 2'd1, 16'hFFFF);
        send_command(spcd_pkg::OP_END, '0, '0, '0);
        send_command(spcd_pkg::OP_ARRIVE, 8'h5A, 2'd3, 16'h0000);
        for (int n = 0; n < 6; n++) begin
            send_command(spcd_pkg::OP_END, '0, '0, '0);
        end
        send_command(spcd_pkg::OP_BEGIN, '0, '0, '0);
    endtask

    initial begin
        int waited;
        error_count = 0;
        server_busy_left = '0;
        tick_counter = '0;
        gaps_on = 1'b1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_tick_and_ignored_op();
        test_priority_and_busy();
        test_queue_overflow();
        test_random_traffic(820);
        test_long_service();
        start <= 1'b0;

        waited = 0;
        while (expected_reports.size() != 0 && waited < 1000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (6) @(posedge i_clk);
        if (expected_reports.size() != 0) begin
            report_mismatch($sformatf("%0d reports never arrived", expected_reports.size()));
        end

        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
src/spcd_pkg.sv
src/spcd_ctrl.sv
src/spcd_dp.sv
src/strict_priority_call_dispatcher_top.sv
verif/tb_strict_priority_call_dispatcher_top.sv
